// ===== rtl/tsbs_pkg.sv =====
// Shared types and constants for the texel store bilinear sampler.
// Used by the config block, the controller, the datapath and the top level.
package tsbs_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam int unsigned DIM_W   = 9;   // width and height registers
  localparam int unsigned POS_W   = 8;   // texel_x and texel_y
  localparam int unsigned FIX_W   = 18;  // signed fixed point, 16 fraction bits
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned IDX_W   = 19;  // linear texel index before memory sizing
  localparam int unsigned NUM_CH  = 4;
  localparam int unsigned TEXEL_W = 32;

  typedef enum logic [1:0] {
    REG_TEX_WIDTH  = 2'd0,
    REG_TEX_HEIGHT = 2'd1,
    REG_FOUR_CH    = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SCALE,
    ST_BASE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RWAIT,
    ST_MULA,
    ST_MULB,
    ST_FIN
  } state_e;

  // Neighbor texel selection: (x,y), (x+1,y), (x,y+1), (x+1,y+1)
  typedef enum logic [1:0] {
    TEX_00 = 2'd0,
    TEX_10 = 2'd1,
    TEX_01 = 2'd2,
    TEX_11 = 2'd3
  } tex_sel_e;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             four_ch;
  } cfg_t;

  typedef struct packed {
    logic     load_in;
    logic     wr_texel;
    logic     clr_step;
    logic     scale;
    logic     base;
    logic     rd_en;
    tex_sel_e rd_sel;
    logic     mul_a;
    logic     mul_b;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_sts_t;

endpackage

// ===== rtl/tsbs_cfg.sv =====
// Configuration registers behind an APB-style port, plus the clamped
// effective texture size. Depends on tsbs_pkg.
module tsbs_cfg
  import tsbs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [DIM_W-1:0] tex_width_q, tex_width_d;
  logic [DIM_W-1:0] tex_height_q, tex_height_d;
  logic             four_ch_q, four_ch_d;
  logic             wr_en;
  reg_idx_e         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1:2]);

  always_comb begin
    tex_width_d  = tex_width_q;
    tex_height_d = tex_height_q;
    four_ch_d    = four_ch_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_TEX_WIDTH:  tex_width_d  = pwdata[DIM_W-1:0];
        REG_TEX_HEIGHT: tex_height_d = pwdata[DIM_W-1:0];
        REG_FOUR_CH:    four_ch_d    = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= DIM_W'(256);
      tex_height_q <= DIM_W'(256);
      four_ch_q    <= 1'b1;
    end else begin
      tex_width_q  <= tex_width_d;
      tex_height_q <= tex_height_d;
      four_ch_q    <= four_ch_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEX_WIDTH:  prdata = APB_DW'(tex_width_q);
      REG_TEX_HEIGHT: prdata = APB_DW'(tex_height_q);
      REG_FOUR_CH:    prdata = APB_DW'(four_ch_q);
      default:        prdata = '0;
    endcase
  end

  // Clamp the size registers to [1, MAX]
  always_comb begin
    if (tex_width_q == '0) begin
      cfg_o.width = DIM_W'(1);
    end else if (32'(tex_width_q) > MAX_WIDTH) begin
      cfg_o.width = DIM_W'(MAX_WIDTH);
    end else begin
      cfg_o.width = tex_width_q;
    end
    if (tex_height_q == '0) begin
      cfg_o.height = DIM_W'(1);
    end else if (32'(tex_height_q) > MAX_HEIGHT) begin
      cfg_o.height = DIM_W'(MAX_HEIGHT);
    end else begin
      cfg_o.height = tex_height_q;
    end
    cfg_o.four_ch = four_ch_q;
  end

endmodule

// ===== rtl/tsbs_ctrl.sv =====
// Sequencer for clear, texel write and sample; owns the output valid flag.
// Depends on tsbs_pkg; drives the datapath through dp_cmd_t.
module tsbs_ctrl
  import tsbs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    kind_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) state_d = kind_i ? ST_SCALE : ST_WRITE;
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_SCALE: state_d = ST_BASE;
      ST_BASE:  state_d = ST_RD0;
      ST_RD0:   state_d = ST_RD1;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = ST_RD3;
      ST_RD3:   state_d = ST_RWAIT;
      ST_RWAIT: state_d = ST_MULA;
      ST_MULA:  state_d = ST_MULB;
      ST_MULB:  state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_WRITE: cmd_o.wr_texel = 1'b1;
      ST_SCALE: cmd_o.scale = 1'b1;
      ST_BASE:  cmd_o.base = 1'b1;
      ST_RD0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = TEX_00;
      end
      ST_RD1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = TEX_10;
      end
      ST_RD2: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = TEX_01;
      end
      ST_RD3: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = TEX_11;
      end
      ST_RWAIT: ;
      ST_MULA:  cmd_o.mul_a = 1'b1;
      ST_MULB:  cmd_o.mul_b = 1'b1;
      ST_FIN:   cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/tsbs_dp.sv =====
// Datapath: input registers, coordinate scaling, texel memory, bilinear
// blend and output registers. Depends on tsbs_pkg; steered by tsbs_ctrl.
module tsbs_dp
  import tsbs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  input  cfg_t             cfg_i,
  input  logic [POS_W-1:0] texel_x_i,
  input  logic [POS_W-1:0] texel_y_i,
  input  logic [FIX_W-1:0] coord_u_i,
  input  logic [FIX_W-1:0] coord_v_i,
  input  logic             bilinear_i,
  input  logic [FIX_W-1:0] wr_red_i,
  input  logic [FIX_W-1:0] wr_green_i,
  input  logic [FIX_W-1:0] wr_blue_i,
  input  logic [FIX_W-1:0] wr_alpha_i,
  output logic [OUT_W-1:0] out_red_o,
  output logic [OUT_W-1:0] out_green_o,
  output logic [OUT_W-1:0] out_blue_o,
  output logic [OUT_W-1:0] out_alpha_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned ProdW = FRAC_W + 1 + DIM_W;   // clamped coord times size
  localparam int unsigned RowW  = 2 * DIM_W;
  localparam int unsigned BlendW = 2 * FRAC_W + 9;

  function automatic logic [7:0] to_byte(logic [FIX_W-1:0] raw);
    if (raw[FIX_W-1]) begin
      return 8'h00;
    end else if (raw[FIX_W-2]) begin
      return 8'hff;
    end else begin
      return raw[15:8];
    end
  endfunction

  // Clamp to [0, 1.0] in raw units
  function automatic logic [FRAC_W:0] clamp_unit(logic [FIX_W-1:0] raw);
    if (raw[FIX_W-1]) begin
      return '0;
    end else if (raw[FIX_W-2]) begin
      return {1'b1, {FRAC_W{1'b0}}};
    end else begin
      return {1'b0, raw[FRAC_W-1:0]};
    end
  endfunction

  function automatic logic [DIM_W-1:0] clamp_top(logic [DIM_W:0] val, logic [DIM_W:0] lim);
    if (val > lim) begin
      return lim[DIM_W-1:0];
    end else begin
      return val[DIM_W-1:0];
    end
  endfunction

  // Input item
  logic [POS_W-1:0]        tx_q, ty_q;
  logic [FIX_W-1:0]        u_q, v_q;
  logic                    bil_q;
  logic [NUM_CH-1:0][7:0]  wb_q;

  // Scaled coordinates and row bases
  logic [DIM_W-1:0]  x_q, x1_q, y_q, y1_q;
  logic [FRAC_W-1:0] fx_q, fy_q;
  logic [RowW-1:0]   row0_q, row1_q;

  logic [ProdW-1:0]  su, sv;
  logic [DIM_W:0]    wm1, hm1;
  logic [DIM_W-1:0]  x_d, y_d;

  // Memory
  logic [TEXEL_W-1:0] tex_mem [Depth];
  logic [TEXEL_W-1:0] rd_data_q;
  logic               mem_we;
  logic [3:0]         mem_be;
  logic [AddrW-1:0]   mem_addr;
  logic [TEXEL_W-1:0] mem_wdata;
  logic [AddrW-1:0]   clr_cnt_q;

  logic              wr_ok;
  logic [POS_W+DIM_W-1:0] wr_row;
  logic [IDX_W-1:0]  wr_idx, rd_idx;
  logic [RowW-1:0]   rd_row;
  logic [DIM_W-1:0]  rd_col;

  logic                         cap_en_q;
  tex_sel_e                     cap_sel_q;
  logic [NUM_CH-1:0][TEXEL_W-1:0] tex_q;

  logic [NUM_CH-1:0][23:0]     top_q, bot_q, top_d, bot_d;
  logic [NUM_CH-1:0][OUT_W-1:0] res_q, res_d;
  logic [FRAC_W:0]             wfx, wfy;

  assign sts_o.clr_last = (clr_cnt_q == AddrW'(Depth - 1));

  // Input capture; channel values become bytes right away
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      tx_q  <= texel_x_i;
      ty_q  <= texel_y_i;
      u_q   <= coord_u_i;
      v_q   <= coord_v_i;
      bil_q <= bilinear_i;
      wb_q  <= {to_byte(wr_alpha_i), to_byte(wr_blue_i), to_byte(wr_green_i),
                to_byte(wr_red_i)};
    end
  end

  // Scale u,v by the texture size; integer part clamped to size-1
  assign su  = ProdW'(clamp_unit(u_q)) * ProdW'(cfg_i.width);
  assign sv  = ProdW'(clamp_unit(v_q)) * ProdW'(cfg_i.height);
  assign wm1 = {1'b0, cfg_i.width} - (DIM_W+1)'(1);
  assign hm1 = {1'b0, cfg_i.height} - (DIM_W+1)'(1);
  assign x_d = clamp_top(su[ProdW-1:FRAC_W], wm1);
  assign y_d = clamp_top(sv[ProdW-1:FRAC_W], hm1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      x_q  <= x_d;
      y_q  <= y_d;
      x1_q <= clamp_top({1'b0, x_d} + (DIM_W+1)'(1), wm1);
      y1_q <= clamp_top({1'b0, y_d} + (DIM_W+1)'(1), hm1);
      fx_q <= su[FRAC_W-1:0];
      fy_q <= sv[FRAC_W-1:0];
    end
    if (cmd_i.base) begin
      row0_q <= RowW'(y_q) * RowW'(cfg_i.width);
      row1_q <= RowW'(y1_q) * RowW'(cfg_i.width);
    end
  end

  // Address generation
  assign wr_ok  = ({1'b0, tx_q} < cfg_i.width) && ({1'b0, ty_q} < cfg_i.height);
  assign wr_row = (POS_W+DIM_W)'(ty_q) * (POS_W+DIM_W)'(cfg_i.width);
  assign wr_idx = IDX_W'(wr_row) + IDX_W'(tx_q);

  always_comb begin
    rd_row = (cmd_i.rd_sel == TEX_01 || cmd_i.rd_sel == TEX_11) ? row1_q : row0_q;
    rd_col = (cmd_i.rd_sel == TEX_10 || cmd_i.rd_sel == TEX_11) ? x1_q : x_q;
    rd_idx = IDX_W'(rd_row) + IDX_W'(rd_col);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_be    = 4'hf;
    mem_wdata = '0;
    mem_addr  = AddrW'(rd_idx);
    if (cmd_i.clr_step) begin
      mem_we   = 1'b1;
      mem_addr = clr_cnt_q;
    end else if (cmd_i.wr_texel) begin
      mem_we    = wr_ok;
      mem_be    = cfg_i.four_ch ? 4'hf : 4'h7;  // keep stored alpha in RGB mode
      mem_wdata = wb_q;
      mem_addr  = AddrW'(wr_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int b = 0; b < 4; b++) begin
        if (mem_be[b]) tex_mem[mem_addr][8*b +: 8] <= mem_wdata[8*b +: 8];
      end
    end
    rd_data_q <= tex_mem[mem_addr];
  end

  // Clear sweep counter and read-return tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      cap_en_q  <= 1'b0;
      cap_sel_q <= TEX_00;
    end else begin
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + AddrW'(1);
      cap_en_q  <= cmd_i.rd_en;
      cap_sel_q <= cmd_i.rd_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_en_q) tex_q[cap_sel_q] <= rd_data_q;
  end

  // Horizontal blend, then vertical blend; truncate once at the end
  assign wfx = {1'b1, {FRAC_W{1'b0}}} - {1'b0, fx_q};
  assign wfy = {1'b1, {FRAC_W{1'b0}}} - {1'b0, fy_q};

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      top_d[ch] = 24'(25'(tex_q[TEX_00][8*ch +: 8]) * 25'(wfx)
                    + 25'(tex_q[TEX_10][8*ch +: 8]) * 25'(fx_q));
      bot_d[ch] = 24'(25'(tex_q[TEX_01][8*ch +: 8]) * 25'(wfx)
                    + 25'(tex_q[TEX_11][8*ch +: 8]) * 25'(fx_q));
    end
  end

  always_comb begin
    logic [BlendW-1:0] blend;
    blend = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      blend = BlendW'(top_q[ch]) * BlendW'(wfy) + BlendW'(bot_q[ch]) * BlendW'(fy_q);
      if (ch == NUM_CH - 1 && !cfg_i.four_ch) begin
        res_d[ch] = '0;
      end else if (!bil_q) begin
        res_d[ch] = {tex_q[TEX_00][8*ch +: 8], 8'h00};
      end else begin
        res_d[ch] = blend[2*FRAC_W+8-1 -: OUT_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      top_q <= top_d;
      bot_q <= bot_d;
    end
    if (cmd_i.mul_b) res_q <= res_d;
    if (cmd_i.out_load) begin
      out_red_o   <= res_q[0];
      out_green_o <= res_q[1];
      out_blue_o  <= res_q[2];
      out_alpha_o <= res_q[3];
    end
  end

endmodule

// ===== rtl/texture_store_bilinear_sampler.sv =====
// Texel store with nearest and bilinear sampling. A write beat is accepted,
// then written with one memory write. A sample beat runs from accept through
// scaling, four reads of the single-port texel memory, two blend multiply
// stages and the output register, which waits while the previous result is
// not yet taken; only then is the next beat accepted. After reset a clearing
// pass zeroes all MAX_WIDTH*MAX_HEIGHT entries (65536 by default); no beat is taken until then.
module texture_store_bilinear_sampler
  import tsbs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [POS_W-1:0]  texel_x_i,
  input  logic [POS_W-1:0]  texel_y_i,
  input  logic [FIX_W-1:0]  coord_u_i,
  input  logic [FIX_W-1:0]  coord_v_i,
  input  logic              bilinear_i,
  input  logic [FIX_W-1:0]  wr_red_i,
  input  logic [FIX_W-1:0]  wr_green_i,
  input  logic [FIX_W-1:0]  wr_blue_i,
  input  logic [FIX_W-1:0]  wr_alpha_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OUT_W-1:0]  out_red_o,
  output logic [OUT_W-1:0]  out_green_o,
  output logic [OUT_W-1:0]  out_blue_o,
  output logic [OUT_W-1:0]  out_alpha_o
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  tsbs_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  tsbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tsbs_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_i      (cfg),
    .texel_x_i  (texel_x_i),
    .texel_y_i  (texel_y_i),
    .coord_u_i  (coord_u_i),
    .coord_v_i  (coord_v_i),
    .bilinear_i (bilinear_i),
    .wr_red_i   (wr_red_i),
    .wr_green_i (wr_green_i),
    .wr_blue_i  (wr_blue_i),
    .wr_alpha_i (wr_alpha_i),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o),
    .out_alpha_o(out_alpha_o)
  );

endmodule

// ===== bench/tsbs_checker.sv =====
// Bench op codes and the scoreboard for the texel store bilinear sampler.
// Mirrors the texel store from the observed write beats and register writes,
// predicts each sample beat and compares it with the result beats in order.
package tsbs_bench_pkg;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } texel_op_e;

endpackage

module tsbs_checker
  import tsbs_pkg::*;
  import tsbs_bench_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              kind_i,
  input  logic [POS_W-1:0]  texel_x_i,
  input  logic [POS_W-1:0]  texel_y_i,
  input  logic [FIX_W-1:0]  coord_u_i,
  input  logic [FIX_W-1:0]  coord_v_i,
  input  logic              bilinear_i,
  input  logic [FIX_W-1:0]  wr_red_i,
  input  logic [FIX_W-1:0]  wr_green_i,
  input  logic [FIX_W-1:0]  wr_blue_i,
  input  logic [FIX_W-1:0]  wr_alpha_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [OUT_W-1:0]  out_red_i,
  input  logic [OUT_W-1:0]  out_green_i,
  input  logic [OUT_W-1:0]  out_blue_i,
  input  logic [OUT_W-1:0]  out_alpha_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o
);

  localparam int unsigned STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int unsigned ONE         = 65536;

  // channel 0 is red, 3 is alpha
  typedef logic [NUM_CH-1:0][OUT_W-1:0] rgba_t;

  logic [TEXEL_W-1:0] texels [STORE_DEPTH];
  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;
  logic               four_ch_q;
  rgba_t              pending_samples [$];

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] r, int unsigned lim);
    if (r == '0) return 1;
    if (r > lim) return lim;
    return r;
  endfunction

  function automatic logic [7:0] fix_to_byte(logic [FIX_W-1:0] raw);
    if (raw[FIX_W-1]) return 8'h00;
    if (raw[16]) return 8'hFF;
    return raw[15:8];
  endfunction

  // clamp to [0,1], scale by n, split into texel index and fraction
  function automatic void scale_coord(input logic [FIX_W-1:0] raw, input int unsigned n,
                                      output int unsigned ip, output int unsigned fp);
    int unsigned c;
    int unsigned s;
    if (raw[FIX_W-1]) c = 0;
    else if (raw > ONE) c = ONE;
    else c = raw;
    s = c * n;
    fp = s & 32'hFFFF;
    ip = s >> FRAC_W;
    if (ip > n - 1) ip = n - 1;
  endfunction

  function automatic void store_texel(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                      logic [FIX_W-1:0] r, logic [FIX_W-1:0] g,
                                      logic [FIX_W-1:0] b, logic [FIX_W-1:0] a);
    int unsigned w;
    int unsigned h;
    int unsigned idx;
    w = clamp_dim(width_q, MAX_WIDTH_DEF);
    h = clamp_dim(height_q, MAX_HEIGHT_DEF);
    if (x >= w || y >= h) return;
    idx = y * w + x;
    if (idx >= STORE_DEPTH) return;
    texels[idx][7:0]   = fix_to_byte(r);
    texels[idx][15:8]  = fix_to_byte(g);
    texels[idx][23:16] = fix_to_byte(b);
    // keep the old alpha in three-channel mode
    if (four_ch_q) texels[idx][31:24] = fix_to_byte(a);
  endfunction

  function automatic rgba_t blend_texels(logic [FIX_W-1:0] u, logic [FIX_W-1:0] v,
                                         logic bil);
    int unsigned       w, h, x, y, fx, fy, x1, y1;
    logic [TEXEL_W-1:0] t00, t10, t01, t11;
    longint unsigned   c00, c10, c01, c11, top_row, bot_row;
    rgba_t             res;
    w = clamp_dim(width_q, MAX_WIDTH_DEF);
    h = clamp_dim(height_q, MAX_HEIGHT_DEF);
    scale_coord(u, w, x, fx);
    scale_coord(v, h, y, fy);
    x1 = (x + 1 > w - 1) ? w - 1 : x + 1;
    y1 = (y + 1 > h - 1) ? h - 1 : y + 1;
    t00 = texels[y * w + x];
    t10 = texels[y * w + x1];
    t01 = texels[y1 * w + x];
    t11 = texels[y1 * w + x1];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      c00 = t00[ch*8 +: 8];
      c10 = t10[ch*8 +: 8];
      c01 = t01[ch*8 +: 8];
      c11 = t11[ch*8 +: 8];
      if (ch == NUM_CH - 1 && !four_ch_q) begin
        res[ch] = '0;
      end else if (!bil) begin
        res[ch] = {t00[ch*8 +: 8], 8'h00};
      end else begin
        top_row = c00 * (ONE - fx) + c10 * fx;
        bot_row = c01 * (ONE - fx) + c11 * fx;
        res[ch] = OUT_W'((top_row * (ONE - fy) + bot_row * fy) >> 24);
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rgba_t want;
    rgba_t got;
    if (!rst_ni) begin
      foreach (texels[i]) texels[i] = '0;
      width_q   = DIM_W'(MAX_WIDTH_DEF);
      height_q  = DIM_W'(MAX_HEIGHT_DEF);
      four_ch_q = 1'b1;
      pending_samples.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_TEX_WIDTH:  width_q   = pwdata[DIM_W-1:0];
          REG_TEX_HEIGHT: height_q  = pwdata[DIM_W-1:0];
          REG_FOUR_CH:    four_ch_q = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = {out_alpha_i, out_blue_i, out_green_i, out_red_i};
        if (pending_samples.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: unexpected result beat r=%h g=%h b=%h a=%h", $time,
                     got[0], got[1], got[2], got[3]);
        end else begin
          want = pending_samples.pop_front();
          if (want !== got) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%0t: sample mismatch: expected r=%h g=%h b=%h a=%h, got r=%h g=%h b=%h a=%h",
                       $time, want[0], want[1], want[2], want[3],
                       got[0], got[1], got[2], got[3]);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (kind_i == OP_SAMPLE)
          pending_samples.push_back(blend_texels(coord_u_i, coord_v_i, bilinear_i));
        else
          store_texel(texel_x_i, texel_y_i, wr_red_i, wr_green_i, wr_blue_i, wr_alpha_i);
      end
      pending_o = pending_samples.size();
    end
  end

endmodule

// ===== bench/texture_store_bilinear_sampler_test.sv =====
// Top of the texel store bilinear sampler bench: clock, reset, register setup,
// write and sample beats, result back-pressure and the verdict.
// Depends on tsbs_pkg and on tsbs_checker for prediction and comparison.
module texture_store_bilinear_sampler_test
  import tsbs_pkg::*;
  import tsbs_bench_pkg::*;
;

  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned NUM_PHASES  = 11;

  typedef struct packed {
    texel_op_e        kind;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [FIX_W-1:0] u;
    logic [FIX_W-1:0] v;
    logic             bil;
    logic [FIX_W-1:0] r;
    logic [FIX_W-1:0] g;
    logic [FIX_W-1:0] b;
    logic [FIX_W-1:0] a;
  } texel_op_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              kind = 1'b0;
  logic [POS_W-1:0]  texel_x = '0;
  logic [POS_W-1:0]  texel_y = '0;
  logic [FIX_W-1:0]  coord_u = '0;
  logic [FIX_W-1:0]  coord_v = '0;
  logic              bilinear = 1'b0;
  logic [FIX_W-1:0]  wr_red = '0;
  logic [FIX_W-1:0]  wr_green = '0;
  logic [FIX_W-1:0]  wr_blue = '0;
  logic [FIX_W-1:0]  wr_alpha = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [OUT_W-1:0]  out_red;
  logic [OUT_W-1:0]  out_green;
  logic [OUT_W-1:0]  out_blue;
  logic [OUT_W-1:0]  out_alpha;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit          held = 1'b0;
  bit          steady_tx = 1'b0;
  int unsigned cur_w = MAX_WIDTH_DEF;
  int unsigned cur_h = MAX_HEIGHT_DEF;

  // width and height registers as written, out-of-range values included
  int unsigned phase_w    [NUM_PHASES] = '{4, 1, 2, 511, 0, 7, 256, 3, 256, 16, 5};
  int unsigned phase_h    [NUM_PHASES] = '{4, 1, 2, 0, 511, 5, 256, 9, 1, 16, 3};
  bit          phase_four [NUM_PHASES] = '{1, 0, 1, 1, 0, 0, 1, 1, 0, 1, 1};
  int unsigned phase_ops  [NUM_PHASES] = '{90, 40, 60, 40, 40, 90, 60, 90, 40, 90, 60};

  texture_store_bilinear_sampler dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .texel_x_i   (texel_x),
    .texel_y_i   (texel_y),
    .coord_u_i   (coord_u),
    .coord_v_i   (coord_v),
    .bilinear_i  (bilinear),
    .wr_red_i    (wr_red),
    .wr_green_i  (wr_green),
    .wr_blue_i   (wr_blue),
    .wr_alpha_i  (wr_alpha),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_red_o   (out_red),
    .out_green_o (out_green),
    .out_blue_o  (out_blue),
    .out_alpha_o (out_alpha)
  );

  tsbs_checker sample_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .kind_i       (kind),
    .texel_x_i    (texel_x),
    .texel_y_i    (texel_y),
    .coord_u_i    (coord_u),
    .coord_v_i    (coord_v),
    .bilinear_i   (bilinear),
    .wr_red_i     (wr_red),
    .wr_green_i   (wr_green),
    .wr_blue_i    (wr_blue),
    .wr_alpha_i   (wr_alpha),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_red_i    (out_red),
    .out_green_i  (out_green),
    .out_blue_i   (out_blue),
    .out_alpha_i  (out_alpha),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(int unsigned r, int unsigned lim);
    if (r == 0) return 1;
    if (r > lim) return lim;
    return r;
  endfunction

  function automatic logic [FIX_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return FIX_W'($urandom);
      1: return FIX_W'(65536 + $urandom_range(0, 65535));
      2: return FIX_W'(-int'($urandom_range(1, 131072)));
      default: return FIX_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly within the first 16 texels so that written texels get sampled
  function automatic logic [FIX_W-1:0] rand_coord(int unsigned n);
    int unsigned span;
    span = (n > 16) ? (16 * 65536) / n : 65536;
    case ($urandom_range(0, 19))
      0: return FIX_W'($urandom);
      1: return '0;
      2: return FIX_W'(65536);
      3: return FIX_W'(-int'($urandom_range(1, 4096)));
      4: return FIX_W'(65536 + $urandom_range(1, 8192));
      default: return FIX_W'($urandom_range(0, span));
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_pos(int unsigned n);
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 255));
    return POS_W'($urandom_range(0, (n > 16 ? 16 : n) - 1));
  endfunction

  function automatic texel_op_t rand_op();
    texel_op_t op;
    op.kind = $urandom_range(0, 1) ? OP_SAMPLE : OP_WRITE;
    op.x    = rand_pos(cur_w);
    op.y    = rand_pos(cur_h);
    op.u    = rand_coord(cur_w);
    op.v    = rand_coord(cur_h);
    op.bil  = ($urandom_range(0, 9) < 7);
    op.r    = rand_chan();
    op.g    = rand_chan();
    op.b    = rand_chan();
    op.a    = rand_chan();
    return op;
  endfunction

  // starts and ends at a falling edge; valid stays high until the next beat or a gap drops it
  task automatic offer_texel_op(texel_op_t op);
    while (!steady_tx && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= op.kind;
    texel_x  <= op.x;
    texel_y  <= op.y;
    coord_u  <= op.u;
    coord_v  <= op.v;
    bilinear <= op.bil;
    wr_red   <= op.r;
    wr_green <= op.g;
    wr_blue  <= op.b;
    wr_alpha <= op.a;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_texel(int unsigned x, int unsigned y, logic [FIX_W-1:0] r,
                             logic [FIX_W-1:0] g, logic [FIX_W-1:0] b,
                             logic [FIX_W-1:0] a);
    texel_op_t op;
    op = rand_op();
    op.kind = OP_WRITE;
    op.x = POS_W'(x);
    op.y = POS_W'(y);
    op.r = r;
    op.g = g;
    op.b = b;
    op.a = a;
    offer_texel_op(op);
  endtask

  task automatic sample_texel(logic [FIX_W-1:0] u, logic [FIX_W-1:0] v, logic bil);
    texel_op_t op;
    op = rand_op();
    op.kind = OP_SAMPLE;
    op.u = u;
    op.v = v;
    op.bil = bil;
    offer_texel_op(op);
  endtask

  // wait out every expected result, then the tail of a trailing write beat
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // setup, access, then an idle gap so that writes never overlap
  task automatic write_reg(reg_idx_e idx, logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_texture(int unsigned w, int unsigned h, bit four);
    settle_block();
    write_reg(REG_TEX_WIDTH, APB_DW'(w));
    write_reg(REG_TEX_HEIGHT, APB_DW'(h));
    write_reg(REG_FOUR_CH, APB_DW'(four));
    cur_w = clamp_dim(w, MAX_WIDTH_DEF);
    cur_h = clamp_dim(h, MAX_HEIGHT_DEF);
  endtask

  initial begin
    texel_op_t   op;
    int unsigned taken;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setup: full 256x256 texture with alpha
    write_texel(0, 0, 18'h1FFFF, 18'h20000, 18'h000FF, 18'h08000);
    write_texel(1, 0, 18'h10000, 18'h3FFFF, 18'h07FFF, 18'h1FFFF);
    write_texel(0, 1, 18'h0C000, 18'h04000, 18'h0FFFF, 18'h00100);
    write_texel(1, 1, 18'h00000, 18'h0FF00, 18'h0A5A5, 18'h05A5A);
    write_texel(255, 255, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
    write_texel(254, 255, 18'h00100, 18'h08000, 18'h0F000, 18'h02000);
    write_texel(255, 254, 18'h0FF00, 18'h00000, 18'h07F00, 18'h0C000);
    write_texel(254, 254, 18'h05500, 18'h0AA00, 18'h03300, 18'h0CC00);
    sample_texel(18'h00000, 18'h00000, 1'b0);
    sample_texel(18'h00000, 18'h00000, 1'b1);
    sample_texel(18'h00080, 18'h00080, 1'b1);
    sample_texel(18'h001FF, 18'h0013F, 1'b1);
    // far edge: neighbors clamp to the last column and row
    sample_texel(18'h10000, 18'h10000, 1'b1);
    sample_texel(18'h0FF80, 18'h0FF80, 1'b1);
    sample_texel(18'h0FF80, 18'h0FE80, 1'b0);
    sample_texel(18'h20000, 18'h1FFFF, 1'b0);
    sample_texel(18'h1FFFF, 18'h20000, 1'b1);
    sample_texel(18'h3FFFF, 18'h000C0, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_texture(phase_w[p], phase_h[p], phase_four[p]);
      steady_tx = (p == 5);
      taken = 0;
      while (taken < phase_ops[p]) begin
        op = rand_op();
        // writes off the texture are dropped by the block and not counted
        if (!(op.kind == OP_WRITE && (op.x >= cur_w || op.y >= cur_h))) taken++;
        offer_texel_op(op);
      end
    end
    steady_tx = 1'b0;

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("texture_store_bilinear_sampler test passed");
    end else begin
      $display("texture_store_bilinear_sampler test failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) results_seen++;
  end

  // result side: random stalls, one long hold-off, one stretch without stalls
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held && results_seen >= 120) begin
        held = 1'b1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (results_seen >= 200 && results_seen < 260) ||
                     ($urandom_range(0, 99) >= 18);
      end
    end
  end

  // covers the store clearing pass after reset as well
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("texture_store_bilinear_sampler test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== texture_store_bilinear_sampler.f =====
rtl/tsbs_pkg.sv
rtl/tsbs_cfg.sv
rtl/tsbs_ctrl.sv
rtl/tsbs_dp.sv
rtl/texture_store_bilinear_sampler.sv
bench/tsbs_checker.sv
bench/texture_store_bilinear_sampler_test.sv
